// File: rtl/core/vpr_pkg.sv
// Shared types, widths and mode codes for the vector projection and rejection core.
// Used by every module in rtl/core except vpr_div; depends on nothing else.
`default_nettype none

package vpr_pkg;

  localparam int ELEM_W     = 32;
  localparam int LANES      = 4;
  localparam int PROD_W     = 64;
  localparam int SQ_W       = 63;
  localparam int DOT_W      = 66;
  localparam int DMAG_W     = 65;
  localparam int DEN_W      = 65;
  localparam int DMAG_LO_W  = 33;
  localparam int DMAG_HI_W  = DMAG_W - DMAG_LO_W;
  localparam int PROJ_Q_W   = 33;
  localparam int SCAL_Q_W   = 65;
  localparam int ROOT_W     = 33;
  localparam int SQ_REM_W   = 36;
  localparam int RES_W      = 36;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_SCALAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROJ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REJECT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic signed [ELEM_W-1:0] left_x;
    logic signed [ELEM_W-1:0] left_y;
    logic signed [ELEM_W-1:0] left_z;
    logic signed [ELEM_W-1:0] left_w;
    logic signed [ELEM_W-1:0] right_x;
    logic signed [ELEM_W-1:0] right_y;
    logic signed [ELEM_W-1:0] right_z;
    logic signed [ELEM_W-1:0] right_w;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_x;
    logic signed [ELEM_W-1:0] out_y;
    logic signed [ELEM_W-1:0] out_z;
    logic signed [ELEM_W-1:0] out_w;
    logic                     zero_norm;
    logic                     last_out;
  } out_word_t;

  typedef struct packed {
    logic [LANES-1:0][ELEM_W-1:0] left;
    logic [LANES-1:0]             rneg;
    logic                         last;
    logic                         zero;
    logic                         dneg;
  } side_t;

  typedef struct packed {
    logic last;
    logic zero;
    logic dneg;
  } tail_t;

  function automatic logic [ELEM_W-1:0] sat_res(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] hi;
    logic signed [RES_W-1:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vpr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the quotient must fit in QBITS bits.
`default_nettype none

module vpr_div #(
  parameter int QBITS = 33,
  parameter int DEN_W = 65
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [QBITS+DEN_W-1:0] num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [QBITS-1:0]       quo
);

  logic [DEN_W-1:0] rem_r [QBITS-1];
  logic [DEN_W-1:0] den_r [QBITS-1];
  logic [QBITS-1:0] qw_r  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QBITS-1:0] qw_in;
    logic [DEN_W:0]   shl;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num[QBITS+DEN_W-1:QBITS];
      assign den_in = den;
      assign qw_in  = num[QBITS-1:0];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign qw_in  = qw_r[k-1];
    end

    assign shl  = {rem_in, qw_in[QBITS-1]};
    assign diff = shl - {1'b0, den_in};
    assign ge   = (shl >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        qw_r[k] <= {qw_in[QBITS-2:0], ge};
      end
    end

    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DEN_W-1:0] : shl[DEN_W-1:0];
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = qw_r[QBITS-1];

endmodule

`default_nettype wire

// File: rtl/core/vpr_dot_lane.sv
// One element lane of the dot products: l*r and r*r, plus the magnitude of r.
// Depends on vpr_pkg.
`default_nettype none

module vpr_dot_lane (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [vpr_pkg::ELEM_W-1:0]   left,
  input  wire logic signed [vpr_pkg::ELEM_W-1:0]   right,
  output logic signed      [vpr_pkg::PROD_W-1:0]   prod_r,
  output logic             [vpr_pkg::SQ_W-1:0]     sq_r,
  output logic             [vpr_pkg::ELEM_W-1:0]   rmag_r,
  output logic                                     rneg_r
);

  logic [vpr_pkg::ELEM_W-1:0] rmag_nxt;
  logic [vpr_pkg::PROD_W-1:0] sq_nxt;

  assign rmag_nxt = right[vpr_pkg::ELEM_W-1] ? (~right + 1'b1) : right;
  assign sq_nxt   = rmag_nxt * rmag_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= left * right;
      sq_r   <= sq_nxt[vpr_pkg::SQ_W-1:0];
      rmag_r <= rmag_nxt;
      rneg_r <= right[vpr_pkg::ELEM_W-1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vpr_proj_lane.sv
// One projection lane: |D|*|r_i| in two partial products, then |D|*|r_i| / S.
// Depends on vpr_pkg and vpr_div.
`default_nettype none

module vpr_proj_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [vpr_pkg::DMAG_W-1:0]    dmag,
  input  wire logic [vpr_pkg::ELEM_W-1:0]    rmag,
  input  wire logic [vpr_pkg::DEN_W-1:0]     den,
  output logic      [vpr_pkg::PROJ_Q_W-1:0]  quo
);

  localparam int NUM_W = vpr_pkg::PROJ_Q_W + vpr_pkg::DEN_W;

  logic [vpr_pkg::DMAG_LO_W+vpr_pkg::ELEM_W-1:0] pa_r;
  logic [vpr_pkg::DMAG_HI_W+vpr_pkg::ELEM_W-1:0] pb_r;
  logic [NUM_W-1:0]                              num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= dmag[vpr_pkg::DMAG_LO_W-1:0] * rmag;
      pb_r  <= dmag[vpr_pkg::DMAG_W-1:vpr_pkg::DMAG_LO_W] * rmag;
      num_r <= NUM_W'({pb_r, {vpr_pkg::DMAG_LO_W{1'b0}}}) + NUM_W'(pa_r);
    end
  end

  vpr_div #(
    .QBITS (vpr_pkg::PROJ_Q_W),
    .DEN_W (vpr_pkg::DEN_W)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (num_r),
    .den (den),
    .quo (quo)
  );

endmodule

`default_nettype wire

// File: rtl/core/vpr_scalar.sv
// Scalar projection magnitude: floor(sqrt(floor(D*D / S))) through a squaring
// stage, a pipelined divider and a pipelined square root. Depends on vpr_pkg, vpr_div.
`default_nettype none

module vpr_scalar (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [vpr_pkg::DMAG_W-1:0]  dmag,
  input  wire logic [vpr_pkg::DEN_W-1:0]   den,
  output logic      [vpr_pkg::ROOT_W-1:0]  root
);

  localparam int LO_W  = vpr_pkg::DMAG_LO_W;
  localparam int HI_W  = vpr_pkg::DMAG_HI_W;
  localparam int NUM_W = vpr_pkg::SCAL_Q_W + vpr_pkg::DEN_W;
  localparam int X_W   = 2 * vpr_pkg::ROOT_W;
  localparam int RT_W  = vpr_pkg::ROOT_W;
  localparam int RM_W  = vpr_pkg::SQ_REM_W;

  logic [2*LO_W-1:0]        sq_lo_r;
  logic [LO_W+HI_W-1:0]     cross_r;
  logic [2*HI_W-1:0]        sq_hi_r;
  logic [NUM_W-1:0]         d2_r;
  logic [vpr_pkg::SCAL_Q_W-1:0] quo;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lo_r <= dmag[LO_W-1:0] * dmag[LO_W-1:0];
      cross_r <= dmag[vpr_pkg::DMAG_W-1:LO_W] * dmag[LO_W-1:0];
      sq_hi_r <= dmag[vpr_pkg::DMAG_W-1:LO_W] * dmag[vpr_pkg::DMAG_W-1:LO_W];
      d2_r    <= NUM_W'({sq_hi_r, {(2*LO_W){1'b0}}})
               + NUM_W'({cross_r, {(LO_W+1){1'b0}}})
               + NUM_W'(sq_lo_r);
    end
  end

  vpr_div #(
    .QBITS (vpr_pkg::SCAL_Q_W),
    .DEN_W (vpr_pkg::DEN_W)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (d2_r),
    .den (den),
    .quo (quo)
  );

  logic [RM_W-1:0] rem_r  [RT_W-1];
  logic [X_W-1:0]  x_r    [RT_W-1];
  logic [RT_W-1:0] root_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    logic [RM_W-1:0] rem_in;
    logic [X_W-1:0]  x_in;
    logic [RT_W-1:0] root_in;
    logic [RM_W-1:0] r4;
    logic [RM_W-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign x_in    = X_W'(quo);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign x_in    = x_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign r4    = {rem_in[RM_W-3:0], x_in[X_W-1:X_W-2]};
    assign trial = RM_W'({root_in, 2'b01});
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[RT_W-2:0], ge};
      end
    end

    if (k < RT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (r4 - trial) : r4;
          x_r[k]   <= {x_in[X_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[RT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/vector_projection_rejection_core.sv
// Top level of the 4-vector projection and rejection core: input skid, dot-product
// lanes, merge, projection lanes, scalar unit and output register. Depends on all rtl/core files.
//
// The core takes one word per clock and delivers one word per clock while out_stall does
// not hold the output. In projection and rejection modes a word's result passes through the
// 33-stage dividers of the projection lanes; in scalar mode it passes through the 65-stage
// divider followed by the 33-stage square root. The whole pipeline halts while a result waits
// under stall; one further word is then taken into the input skid register before in_stall
// rises.
`default_nettype none

module vector_projection_rejection_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire vpr_pkg::in_word_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output vpr_pkg::out_word_t                out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [vpr_pkg::MODE_W-1:0]   cfg_wr_data
);

  localparam int LANES       = vpr_pkg::LANES;
  localparam int EW          = vpr_pkg::ELEM_W;
  localparam int STAGES_PROJ = 5 + vpr_pkg::PROJ_Q_W;
  localparam int STAGES_SCAL = STAGES_PROJ + vpr_pkg::SCAL_Q_W + vpr_pkg::ROOT_W
                               - vpr_pkg::PROJ_Q_W;
  localparam int SB_N        = STAGES_PROJ - 2;
  localparam int TAIL_N      = STAGES_SCAL - STAGES_PROJ;

  logic [vpr_pkg::MODE_W-1:0] mode_r;
  logic                       skid_valid_r;
  vpr_pkg::in_word_t          skid_data_r;
  vpr_pkg::in_word_t          src;
  logic                       src_valid;
  logic                       en;
  logic [STAGES_SCAL-1:0]     vld_r;
  logic                       out_valid_r;
  vpr_pkg::out_word_t         out_r;
  vpr_pkg::out_word_t         out_nxt;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign src       = skid_valid_r ? skid_data_r : in_data;
  assign src_valid = skid_valid_r || in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vpr_pkg::MODE_PROJ;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_valid_r) begin
      skid_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES_SCAL-2:0], src_valid};
    end
  end

  // Stage 1: element products.
  logic signed [EW-1:0]              src_l [LANES];
  logic signed [EW-1:0]              src_r [LANES];
  logic signed [vpr_pkg::PROD_W-1:0] lane_prod [LANES];
  logic [vpr_pkg::SQ_W-1:0]          lane_sq   [LANES];
  logic [EW-1:0]                     lane_rmag [LANES];
  logic [LANES-1:0]                  lane_rneg;

  assign src_l[0] = src.left_x;
  assign src_l[1] = src.left_y;
  assign src_l[2] = src.left_z;
  assign src_l[3] = src.left_w;
  assign src_r[0] = src.right_x;
  assign src_r[1] = src.right_y;
  assign src_r[2] = src.right_z;
  assign src_r[3] = src.right_w;

  for (genvar i = 0; i < LANES; i++) begin : g_dot
    vpr_dot_lane u_lane (
      .clk    (clk),
      .en     (en),
      .left   (src_l[i]),
      .right  (src_r[i]),
      .prod_r (lane_prod[i]),
      .sq_r   (lane_sq[i]),
      .rmag_r (lane_rmag[i]),
      .rneg_r (lane_rneg[i])
    );
  end

  logic [LANES-1:0][EW-1:0] l1_r;
  logic                     last1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r    <= {src.left_w, src.left_z, src.left_y, src.left_x};
      last1_r <= src.last_in;
    end
  end

  // Stage 2: merge the lanes into D and S.
  logic signed [vpr_pkg::DOT_W-1:0] d2_r;
  logic [vpr_pkg::DEN_W-1:0]        s2_r;
  logic [LANES-1:0][EW-1:0]         l2_r;
  logic [LANES-1:0]                 rneg2_r;
  logic [EW-1:0]                    rmag2_r [LANES];
  logic                             last2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r    <= vpr_pkg::DOT_W'(lane_prod[0]) + vpr_pkg::DOT_W'(lane_prod[1])
               + vpr_pkg::DOT_W'(lane_prod[2]) + vpr_pkg::DOT_W'(lane_prod[3]);
      s2_r    <= vpr_pkg::DEN_W'(lane_sq[0]) + vpr_pkg::DEN_W'(lane_sq[1])
               + vpr_pkg::DEN_W'(lane_sq[2]) + vpr_pkg::DEN_W'(lane_sq[3]);
      l2_r    <= l1_r;
      rneg2_r <= lane_rneg;
      rmag2_r <= lane_rmag;
      last2_r <= last1_r;
    end
  end

  // Stage 3: magnitude and sign of D.
  logic signed [vpr_pkg::DOT_W-1:0] dabs;
  logic [vpr_pkg::DMAG_W-1:0]       dmag3_r;
  logic [vpr_pkg::DEN_W-1:0]        s3_r;
  logic [vpr_pkg::DEN_W-1:0]        s4_r;
  logic [vpr_pkg::DEN_W-1:0]        s5_r;
  logic [EW-1:0]                    rmag3_r [LANES];
  vpr_pkg::side_t                   sb_r [SB_N];
  vpr_pkg::tail_t                   tl_r [TAIL_N];

  assign dabs = d2_r[vpr_pkg::DOT_W-1] ? -d2_r : d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dmag3_r       <= dabs[vpr_pkg::DMAG_W-1:0];
      s3_r          <= s2_r;
      s4_r          <= s3_r;
      s5_r          <= s4_r;
      rmag3_r       <= rmag2_r;
      sb_r[0].left  <= l2_r;
      sb_r[0].rneg  <= rneg2_r;
      sb_r[0].last  <= last2_r;
      sb_r[0].zero  <= (s2_r == '0);
      sb_r[0].dneg  <= d2_r[vpr_pkg::DOT_W-1];
      for (int k = 1; k < SB_N; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      tl_r[0].last <= sb_r[SB_N-1].last;
      tl_r[0].zero <= sb_r[SB_N-1].zero;
      tl_r[0].dneg <= sb_r[SB_N-1].dneg;
      for (int k = 1; k < TAIL_N; k++) begin
        tl_r[k] <= tl_r[k-1];
      end
    end
  end

  logic [vpr_pkg::PROJ_Q_W-1:0] proj_q [LANES];
  logic [vpr_pkg::ROOT_W-1:0]   root;

  for (genvar i = 0; i < LANES; i++) begin : g_proj
    vpr_proj_lane u_lane (
      .clk  (clk),
      .en   (en),
      .dmag (dmag3_r),
      .rmag (rmag3_r[i]),
      .den  (s5_r),
      .quo  (proj_q[i])
    );
  end

  vpr_scalar u_scalar (
    .clk  (clk),
    .en   (en),
    .dmag (dmag3_r),
    .den  (s5_r),
    .root (root)
  );

  // Output stage: sign, rejection, zero-vector handling and saturation.
  logic                           sel_scal;
  logic                           tap_valid;
  logic                           tap_zero;
  logic                           tap_dneg;
  logic                           tap_last;
  logic signed [vpr_pkg::RES_W-1:0] sval;
  logic [EW-1:0]                  res [LANES];

  assign sel_scal  = (mode_r == vpr_pkg::MODE_SCALAR);
  assign tap_valid = sel_scal ? vld_r[STAGES_SCAL-1] : vld_r[STAGES_PROJ-1];
  assign tap_zero  = sel_scal ? tl_r[TAIL_N-1].zero : sb_r[SB_N-1].zero;
  assign tap_dneg  = sel_scal ? tl_r[TAIL_N-1].dneg : sb_r[SB_N-1].dneg;
  assign tap_last  = sel_scal ? tl_r[TAIL_N-1].last : sb_r[SB_N-1].last;
  assign sval      = tap_dneg ? -vpr_pkg::RES_W'(root) : vpr_pkg::RES_W'(root);

  always_comb begin
    logic signed [vpr_pkg::RES_W-1:0] lv;
    logic signed [vpr_pkg::RES_W-1:0] pv;
    logic signed [vpr_pkg::RES_W-1:0] rv;
    for (int i = 0; i < LANES; i++) begin
      lv = vpr_pkg::RES_W'($signed(sb_r[SB_N-1].left[i]));
      pv = (tap_dneg ^ sb_r[SB_N-1].rneg[i]) ? -vpr_pkg::RES_W'(proj_q[i])
                                            : vpr_pkg::RES_W'(proj_q[i]);
      if (tap_zero) begin
        rv = mode_r[1] ? lv : '0;
      end else if (sel_scal) begin
        rv = sval;
      end else if (mode_r[1]) begin
        rv = lv - pv;
      end else begin
        rv = pv;
      end
      res[i] = vpr_pkg::sat_res(rv);
    end
    out_nxt.out_x     = res[0];
    out_nxt.out_y     = res[1];
    out_nxt.out_z     = res[2];
    out_nxt.out_w     = res[3];
    out_nxt.zero_norm = tap_zero;
    out_nxt.last_out  = tap_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  skid_fills_only_on_halt: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(!en))
    else $error("input skid register filled while the pipeline advanced");

  skid_holds_on_halt: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !en |=> skid_valid_r)
    else $error("input skid word lost during a halt");

  scalar_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r == vpr_pkg::MODE_SCALAR |->
      out_r.out_x == out_r.out_y && out_r.out_y == out_r.out_z &&
      out_r.out_z == out_r.out_w)
    else $error("scalar mode word carries differing components");

  zero_vector_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.zero_norm && !mode_r[1] |->
      out_r.out_x == '0 && out_r.out_y == '0 && out_r.out_z == '0 && out_r.out_w == '0)
    else $error("zero plane vector gave a non-zero projection");

endmodule

`default_nettype wire

// File: verif/vpr_result_checker.sv
// Result checker for vector_projection_rejection_core: watches the input, result and
// register ports, predicts every result word and compares it with what the core delivers.
// Depends on vpr_pkg only.
module vpr_result_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  vpr_pkg::in_word_t        in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  vpr_pkg::out_word_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic [vpr_pkg::MODE_W-1:0] cfg_wr_data,
  output int                       fail_count,
  output int                       pending
);

  logic [vpr_pkg::MODE_W-1:0] mode_copy;
  vpr_pkg::out_word_t         expected_words[$];

  function automatic logic [31:0] clamp32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic vpr_pkg::out_word_t project_word(input vpr_pkg::in_word_t w,
                                                      input logic [vpr_pkg::MODE_W-1:0] md);
    logic signed [31:0] lv[4];
    logic signed [31:0] rv[4];
    logic signed [67:0] dot;
    logic signed [67:0] nrm;
    logic signed [67:0] v;
    logic [159:0] dmag;
    logic [159:0] den;
    logic [159:0] q;
    logic [159:0] cand;
    logic [159:0] ar;
    logic [34:0] root;
    logic [31:0] res[4];
    logic dneg;
    vpr_pkg::out_word_t o;
    lv = '{w.left_x, w.left_y, w.left_z, w.left_w};
    rv = '{w.right_x, w.right_y, w.right_z, w.right_w};
    dot = 0;
    nrm = 0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + (longint'(lv[i]) * longint'(rv[i]));
      nrm = nrm + (longint'(rv[i]) * longint'(rv[i]));
    end
    dneg = dot < 0;
    dmag = dneg ? 160'(-dot) : 160'(dot);
    den = 160'(nrm);
    if (nrm == 0) begin
      for (int i = 0; i < 4; i++) res[i] = md[1] ? lv[i] : 32'd0;
    end else if (md == vpr_pkg::MODE_SCALAR) begin
      q = (dmag * dmag) / den;
      root = '0;
      for (int b = 34; b >= 0; b--) begin
        cand = 160'(root | (35'd1 << b));
        if (cand * cand <= q) root = cand[34:0];
      end
      v = dneg ? -68'(root) : 68'(root);
      for (int i = 0; i < 4; i++) res[i] = clamp32(v);
    end else begin
      for (int i = 0; i < 4; i++) begin
        ar = rv[i] < 0 ? 160'(-longint'(rv[i])) : 160'(longint'(rv[i]));
        q = (dmag * ar) / den;
        if (q > 160'h100_0000_0000) q = 160'h100_0000_0000;
        v = (dneg != (rv[i] < 0)) ? -68'(q[40:0]) : 68'(q[40:0]);
        res[i] = md[1] ? clamp32(68'(lv[i]) - v) : clamp32(v);
      end
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    o.out_w = res[3];
    o.zero_norm = (nrm == 0);
    o.last_out = w.last_in;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vpr_pkg::out_word_t e;
    if (!rst_n) begin
      mode_copy = vpr_pkg::MODE_PROJ;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("unexpected result word at %0t", $realtime);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (out_data.out_x !== e.out_x) report_mismatch("out_x", out_data.out_x, e.out_x);
          if (out_data.out_y !== e.out_y) report_mismatch("out_y", out_data.out_y, e.out_y);
          if (out_data.out_z !== e.out_z) report_mismatch("out_z", out_data.out_z, e.out_z);
          if (out_data.out_w !== e.out_w) report_mismatch("out_w", out_data.out_w, e.out_w);
          if (out_data.zero_norm !== e.zero_norm)
            report_mismatch("zero_norm", out_data.zero_norm, e.zero_norm);
          if (out_data.last_out !== e.last_out)
            report_mismatch("last_out", out_data.last_out, e.last_out);
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(project_word(in_data, mode_copy));
      if (cfg_wr_en) mode_copy = cfg_wr_data;
    end
    pending = expected_words.size();
  end
endmodule

// File: verif/tb_top.sv
// Top of the testbench for vector_projection_rejection_core: clock, reset, stimulus,
// stall pattern and verdict. Depends on vpr_pkg, the core and vpr_result_checker.
module tb_top;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  vpr_pkg::in_word_t          in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  vpr_pkg::out_word_t         out_data;
  logic                       cfg_wr_en = 1'b0;
  logic [vpr_pkg::MODE_W-1:0] cfg_wr_data = '0;
  int                         fail_count;
  int                         pending;
  int                         cycles = 0;
  bit                         hold_free = 1'b0;

  vector_projection_rejection_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  vpr_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Stall in bursts; some stretches are left entirely free of stall.
  always @(negedge clk) begin
    int run;
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) hold_free = !hold_free;
      run = gap_length();
      if (!hold_free && run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 16)) - 8) << 16;
      4: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input vpr_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    vpr_pkg::in_word_t w;
    int gap;
    for (int n = 0; n < count; n++) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 1'($urandom)};
      if ($urandom_range(0, 3) != 0) begin
        w.left_x = pick_elem(); w.left_y = pick_elem();
        w.left_z = pick_elem(); w.left_w = pick_elem();
        w.right_x = pick_elem(); w.right_y = pick_elem();
        w.right_z = pick_elem(); w.right_w = pick_elem();
      end
      if ($urandom_range(0, 15) == 0) begin
        w.right_x = 0; w.right_y = 0; w.right_z = 0; w.right_w = 0;
      end
      in_valid <= 1'b1;
      in_data <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      gap = gap_length();
      if (gap > 0 || n == count - 1) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_directed();
    logic [31:0] mx;
    logic [31:0] mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_word({mx, mx, mx, mx, mx, mx, mx, mx, 1'b0});
    send_word({mn, mn, mn, mn, mn, mn, mn, mn, 1'b1});
    send_word({mx, mx, mx, mx, mn, mn, mn, mn, 1'b0});
    send_word({mn, mx, mn, mx, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    send_word({mx, mn, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
    send_word({32'd0, 32'd0, 32'd0, 32'd0, mn, 32'd1, 32'd0, 32'd0, 1'b0});
    send_word({32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0,
               32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b1});
    send_word({mn, mn, mn, mn, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0});
    send_word({32'hFFFF_FFFF, 32'd3, 32'd0, 32'hFFFF_0000,
               32'd0, 32'd0, 32'd0, 32'h0000_0001, 1'b0});
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [vpr_pkg::MODE_W-1:0] md);
    wait (pending == 0);
    repeat (110) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= md;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_directed();
    send_random(130);
    set_mode(vpr_pkg::MODE_SCALAR);
    send_directed();
    send_random(130);
    set_mode(vpr_pkg::MODE_REJECT);
    send_directed();
    send_random(130);
    set_mode(vpr_pkg::MODE_SPARE);
    send_directed();
    send_random(60);
    set_mode(vpr_pkg::MODE_PROJ);
    send_random(100);
    wait (pending == 0);
    repeat (120) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
